### hw/rtl/gdn_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date/time normalizer.
// Used by gdn_ctrl, gdn_datapath and gregorian_datetime_normalizer; no dependencies.

package gdn_pkg;

  // Working width of the field registers: the 16-bit inputs plus carry growth.
  localparam int WORK_W = 18;
  typedef logic signed [WORK_W-1:0] wval_t;

  // First year for which the calendar is carried.
  localparam logic signed [15:0]       FIRST_YEAR_IN = 16'sd1582;
  localparam logic signed [WORK_W-1:0] FIRST_YEAR_W  = 18'sd1582;

  // Shift of the reciprocal multiply in the divider.
  localparam int RECIP_SHIFT = 17;

  // Divisibility by 25: multiply by the inverse of 25 mod 2^16 and compare.
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_MAX = 16'd2621;

  // Month lengths in a common year, January first.
  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Which field the shared divider works on.
  typedef enum logic [2:0] {
    OP_MS,
    OP_SEC,
    OP_MIN,
    OP_HOUR,
    OP_MONTH
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_a;
    logic div_b;
    op_t  op;
    logic prep;
    logic fstep;
    logic bstep;
    logic badd;
    logic publish;
  } gdn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dated;
    logic day_lt1;
    logic fwd_more;
    logic b_err;
    logic badd_lt1;
    logic out_free;
  } gdn_status_t;

  // Divisor of each step.
  function automatic logic [9:0] div_mod(op_t op);
    logic [9:0] m;
    unique case (op)
      OP_MS:   m = 10'd1000;
      OP_SEC:  m = 10'd60;
      OP_MIN:  m = 10'd60;
      OP_HOUR: m = 10'd24;
      default: m = 10'd12;
    endcase
    return m;
  endfunction

  // floor(2^RECIP_SHIFT / divisor).
  function automatic logic [13:0] div_recip(op_t op);
    logic [13:0] r;
    unique case (op)
      OP_MS:   r = 14'd131;
      OP_SEC:  r = 14'd2184;
      OP_MIN:  r = 14'd2184;
      OP_HOUR: r = 14'd5461;
      default: r = 14'd10922;
    endcase
    return r;
  endfunction

  // Bias count K: the operand is offset by K*divisor so it is never negative.
  function automatic logic [12:0] div_k(op_t op);
    logic [12:0] k;
    unique case (op)
      OP_MS:   k = 13'd66;
      OP_SEC:  k = 13'd1093;
      OP_MIN:  k = 13'd1093;
      OP_HOUR: k = 13'd2731;
      default: k = 13'd5462;
    endcase
    return k;
  endfunction

  // K*divisor.
  function automatic logic [16:0] div_bias(op_t op);
    logic [16:0] b;
    unique case (op)
      OP_MS:   b = 17'd66000;
      OP_SEC:  b = 17'd65580;
      OP_MIN:  b = 17'd65580;
      OP_HOUR: b = 17'd65544;
      default: b = 17'd65544;
    endcase
    return b;
  endfunction

  // Leap year test for a positive year below 2^16.
  function automatic logic is_leap(logic [15:0] y);
    logic [15:0] p;
    logic        div25;
    p     = 16'(y * INV25);
    div25 = (p <= DIV25_MAX);
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  // Days in month 1..12.
  function automatic logic [4:0] days_in(logic [3:0] month, logic leap);
    logic [3:0] idx;
    idx = month - 4'd1;
    return MONTH_LEN[idx] + ((month == 4'd2) ? {4'd0, leap} : 5'd0);
  endfunction

endpackage

### hw/rtl/gdn_ctrl.sv
// Controller state machine of the date/time normalizer: sequences divides and day steps.
// Depends on gdn_pkg (command, status and op types).

module gdn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output gdn_pkg::gdn_cmd_t   cmd,
  input  gdn_pkg::gdn_status_t st
);
  import gdn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVA,
    S_DIVB,
    S_PREP,
    S_FSTEP,
    S_BSTEP,
    S_BADD,
    S_FINISH
  } state_t;

  state_t state;
  op_t    op;
  logic   back;

  // State, current divide step and day-walk direction
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_MS;
      back  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIVA;
            op    <= OP_MS;
          end
        end
        S_DIVA: state <= S_DIVB;
        S_DIVB: begin
          unique case (op)
            OP_MS: begin
              op    <= OP_SEC;
              state <= S_DIVA;
            end
            OP_SEC: begin
              op    <= OP_MIN;
              state <= S_DIVA;
            end
            OP_MIN: begin
              op    <= OP_HOUR;
              state <= S_DIVA;
            end
            OP_HOUR: begin
              if (st.dated) begin
                op    <= OP_MONTH;
                state <= S_DIVA;
              end else begin
                state <= S_FINISH;
              end
            end
            default: begin
              // month folded; walk days backward or forward
              if (st.day_lt1) begin
                back  <= 1'b1;
                state <= S_BSTEP;
              end else begin
                back  <= 1'b0;
                state <= S_PREP;
              end
            end
          endcase
        end
        S_PREP:  state <= back ? S_BADD : S_FSTEP;
        S_FSTEP: state <= st.fwd_more ? S_PREP : S_FINISH;
        S_BSTEP: state <= st.b_err ? S_FINISH : S_PREP;
        S_BADD:  state <= st.badd_lt1 ? S_BSTEP : S_FINISH;
        S_FINISH: begin
          if (st.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command decode
  assign in_ready    = (state == S_IDLE);
  assign cmd.load    = in_valid && (state == S_IDLE);
  assign cmd.div_a   = (state == S_DIVA);
  assign cmd.div_b   = (state == S_DIVB);
  assign cmd.op      = op;
  assign cmd.prep    = (state == S_PREP);
  assign cmd.fstep   = (state == S_FSTEP);
  assign cmd.bstep   = (state == S_BSTEP);
  assign cmd.badd    = (state == S_BADD);
  assign cmd.publish = (state == S_FINISH) && st.out_free;

  // Never overwrite a result that has not been taken
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> st.out_free)
    else $error("publish while output register busy");

  // Time-only transactions skip the date walk
  a_undated_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVB && op == OP_HOUR && !st.dated) |=> (state == S_FINISH))
    else $error("undated transaction entered date walk");

  // Forward walk ends once the day fits the month
  a_fwd_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.fstep && !st.fwd_more) |=> (state == S_FINISH))
    else $error("forward walk did not finish");

endmodule

### hw/rtl/gdn_datapath.sv
// Datapath of the date/time normalizer: field registers, shared constant divider,
// leap/month-length logic and the output register. Depends on gdn_pkg.

module gdn_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  gdn_pkg::gdn_cmd_t    cmd,
  output gdn_pkg::gdn_status_t st,
  input  logic signed [15:0]   in_year,
  input  logic signed [15:0]   in_month,
  input  logic signed [15:0]   in_day,
  input  logic signed [15:0]   in_hour,
  input  logic signed [15:0]   in_minute,
  input  logic signed [15:0]   in_second,
  input  logic signed [15:0]   in_millisecond,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_year,
  output logic signed [15:0]   out_month,
  output logic signed [15:0]   out_day,
  output logic [4:0]           out_hour,
  output logic [5:0]           out_minute,
  output logic [5:0]           out_second,
  output logic [9:0]           out_millisecond,
  output logic                 date_adjusted,
  output logic                 range_error
);
  import gdn_pkg::*;

  // Working fields
  wval_t year, month, day, hour, minute, second, msec;
  // Original date and time, for pass-through and error return
  logic signed [15:0] orig_year, orig_month, orig_day;
  logic        [15:0] orig_hour, orig_minute, orig_second, orig_msec;
  logic dated;
  logic err;

  // Divider registers
  logic [16:0] u_reg;
  logic [13:0] qe_reg;

  // Calendar registers from the prep cycle
  logic [4:0] dom;
  logic [8:0] ylen;

  // Divider, first cycle: bias operand, estimate quotient by reciprocal
  wval_t       v_sel;
  wval_t       u_sum;
  logic [30:0] prod;
  logic [13:0] qe_next;

  always_comb begin
    unique case (cmd.op)
      OP_MS:   v_sel = msec;
      OP_SEC:  v_sel = second;
      OP_MIN:  v_sel = minute;
      OP_HOUR: v_sel = hour;
      default: v_sel = month - 18'sd1;
    endcase
  end

  assign u_sum   = v_sel + $signed({1'b0, div_bias(cmd.op)});
  assign prod    = {14'd0, u_sum[16:0]} * {17'd0, div_recip(cmd.op)};
  assign qe_next = prod[30:RECIP_SHIFT];

  // Divider, second cycle: remainder with one correction step
  logic [9:0]  m_cur;
  logic [23:0] prod2;
  logic [16:0] r0;
  logic [10:0] r_low;
  logic        fix;
  logic [10:0] r_fin;
  logic [13:0] q_fin;
  wval_t       r_ext;
  wval_t       qd;

  assign m_cur = div_mod(cmd.op);
  assign prod2 = {10'd0, qe_reg} * {14'd0, m_cur};
  assign r0    = u_reg - prod2[16:0];
  assign r_low = r0[10:0];
  assign fix   = (r_low >= {1'b0, m_cur});
  assign r_fin = fix ? (r_low - {1'b0, m_cur}) : r_low;
  assign q_fin = qe_reg + {13'd0, fix};
  assign r_ext = $signed({7'd0, r_fin});
  assign qd    = $signed({4'd0, q_fin}) - $signed({5'd0, div_k(cmd.op)});

  // Leap and month length for the prep cycle
  logic [3:0]  month_lo;
  logic [15:0] year_p1;
  logic        leap_cur, leap_nxt;

  assign month_lo = month[3:0];
  assign year_p1  = year[15:0] + 16'd1;
  assign leap_cur = is_leap(year[15:0]);
  assign leap_nxt = is_leap(year_p1);

  // Day walk comparisons
  wval_t dom_w, ylen_w, day_badd;
  wval_t month_b, year_b;
  logic  fwd_year, fwd_month;

  assign dom_w     = $signed({13'd0, dom});
  assign ylen_w    = $signed({9'd0, ylen});
  assign fwd_year  = (day > ylen_w);
  assign fwd_month = (day > dom_w);
  assign day_badd  = day + dom_w;
  assign month_b   = (month == 18'sd1) ? 18'sd12 : (month - 18'sd1);
  assign year_b    = (month == 18'sd1) ? (year - 18'sd1) : year;

  assign st.dated    = dated;
  assign st.day_lt1  = (day < 18'sd1);
  assign st.fwd_more = fwd_year || fwd_month;
  assign st.b_err    = (year_b < FIRST_YEAR_W);
  assign st.badd_lt1 = (day_badd < 18'sd1);
  assign st.out_free = !out_valid || out_ready;

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year        <= {{2{in_year[15]}}, in_year};
      month       <= {{2{in_month[15]}}, in_month};
      day         <= {{2{in_day[15]}}, in_day};
      hour        <= {{2{in_hour[15]}}, in_hour};
      minute      <= {{2{in_minute[15]}}, in_minute};
      second      <= {{2{in_second[15]}}, in_second};
      msec        <= {{2{in_millisecond[15]}}, in_millisecond};
      orig_year   <= in_year;
      orig_month  <= in_month;
      orig_day    <= in_day;
      orig_hour   <= in_hour;
      orig_minute <= in_minute;
      orig_second <= in_second;
      orig_msec   <= in_millisecond;
      dated       <= (in_year > FIRST_YEAR_IN) && (in_month > 16'sd0) && (in_day > 16'sd0);
      err         <= 1'b0;
    end
    if (cmd.div_a) begin
      u_reg  <= u_sum[16:0];
      qe_reg <= qe_next;
    end
    if (cmd.div_b) begin
      unique case (cmd.op)
        OP_MS: begin
          msec   <= r_ext;
          second <= second + qd;
        end
        OP_SEC: begin
          second <= r_ext;
          minute <= minute + qd;
        end
        OP_MIN: begin
          minute <= r_ext;
          hour   <= hour + qd;
        end
        OP_HOUR: begin
          hour <= r_ext;
          if (dated) begin
            day <= day + qd;
          end
        end
        default: begin
          month <= r_ext + 18'sd1;
          year  <= year + qd;
        end
      endcase
    end
    if (cmd.prep) begin
      dom  <= days_in(month_lo, leap_cur);
      ylen <= 9'd365 + {8'd0, (month_lo <= 4'd2) ? leap_cur : leap_nxt};
    end
    // Forward: skip a whole year when the next twelve months fit, else one month
    if (cmd.fstep) begin
      if (fwd_year) begin
        day  <= day - ylen_w;
        year <= year + 18'sd1;
      end else if (fwd_month) begin
        day <= day - dom_w;
        if (month == 18'sd12) begin
          month <= 18'sd1;
          year  <= year + 18'sd1;
        end else begin
          month <= month + 18'sd1;
        end
      end
    end
    // Backward: enter the previous month, flag a borrow below the first year
    if (cmd.bstep) begin
      if (year_b < FIRST_YEAR_W) begin
        err <= 1'b1;
      end else begin
        month <= month_b;
        year  <= year_b;
      end
    end
    if (cmd.badd) begin
      day <= day_badd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      date_adjusted <= dated && !err;
      range_error   <= err;
      if (err) begin
        out_year        <= orig_year;
        out_month       <= orig_month;
        out_day         <= orig_day;
        out_hour        <= orig_hour[4:0];
        out_minute      <= orig_minute[5:0];
        out_second      <= orig_second[5:0];
        out_millisecond <= orig_msec[9:0];
      end else begin
        if (dated) begin
          out_year  <= year[15:0];
          out_month <= month[15:0];
          out_day   <= day[15:0];
        end else begin
          out_year  <= orig_year;
          out_month <= orig_month;
          out_day   <= orig_day;
        end
        out_hour        <= hour[4:0];
        out_minute      <= minute[5:0];
        out_second      <= second[5:0];
        out_millisecond <= msec[9:0];
      end
    end
  end

  // A transaction may be carried or flagged, never both
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(range_error && date_adjusted))
    else $error("range_error and date_adjusted both set");

  // Normalized time lies in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !range_error) |->
      (out_hour < 5'd24) && (out_minute < 6'd60) &&
      (out_second < 6'd60) && (out_millisecond < 10'd1000))
    else $error("time field out of range");

  // Carried dates have a real month
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && date_adjusted) |-> (out_month >= 16'sd1) && (out_month <= 16'sd12))
    else $error("month out of range");

  // Prep always sees a folded month
  a_prep_month: assert property (@(posedge clk) disable iff (rst)
    cmd.prep |-> (month >= 18'sd1) && (month <= 18'sd12))
    else $error("month not folded before day walk");

endmodule

### hw/rtl/gregorian_datetime_normalizer.sv
// Top level of the Gregorian date/time normalizer: controller plus datapath.
// Depends on gdn_pkg, gdn_ctrl and gdn_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   input   | in_valid / in_ready  | in_year .. in_millisecond (16-bit signed)
//   output  | out_valid / out_ready| out_year .. out_millisecond, date_adjusted,
//           |                      | range_error
//
// One transaction at a time. Time-only items are accepted, run the constant
// divides (1000, 60, 60, 24; reciprocal multiply then remainder fix-up) and
// load the output register once it is free. Dated items add one divide by 12,
// then a day walk: each prep and step skips a year or steps a month forward;
// each step, prep and add steps a month backward.
// Reset (rst, synchronous) empties the output register and returns to idle.
// A result waits in the output register while the next item is accepted; the
// controller holds the following result until that register is free.

module gregorian_datetime_normalizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_year,
  input  logic signed [15:0] in_month,
  input  logic signed [15:0] in_day,
  input  logic signed [15:0] in_hour,
  input  logic signed [15:0] in_minute,
  input  logic signed [15:0] in_second,
  input  logic signed [15:0] in_millisecond,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_year,
  output logic signed [15:0] out_month,
  output logic signed [15:0] out_day,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second,
  output logic [9:0]         out_millisecond,
  output logic               date_adjusted,
  output logic               range_error
);
  import gdn_pkg::*;

  gdn_cmd_t    cmd;
  gdn_status_t st;

  gdn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  gdn_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .in_year         (in_year),
    .in_month        (in_month),
    .in_day          (in_day),
    .in_hour         (in_hour),
    .in_minute       (in_minute),
    .in_second       (in_second),
    .in_millisecond  (in_millisecond),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second),
    .out_millisecond (out_millisecond),
    .date_adjusted   (date_adjusted),
    .range_error     (range_error)
  );

endmodule
